// ----- rtl/mvts_pkg.sv -----
// Shared types and constants for the min-vruntime task scheduler.
`timescale 1ns / 1ps

package mvts_pkg;

    localparam int ID_W       = 16;
    localparam int RT_W       = 48;
    localparam int QUANT_W    = 16;
    localparam int HELD_W     = 7;
    localparam int ENTRY_W    = ID_W + RT_W;
    localparam int IN_DATA_W  = ID_W + RT_W;
    localparam int OUT_DATA_W = ID_W + RT_W + 1 + ID_W + RT_W + HELD_W;
    localparam int STATUS_W   = 2;

    localparam logic [QUANT_W-1:0] QUANT_RESET = 16'd4;

    typedef enum logic
    {
        OP_ADD,
        OP_RUN
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_OK,
        ST_FULL,
        ST_EMPTY
    } status_t;

    // controller -> datapath
    typedef struct packed
    {
        logic load_in;
        logic exec_add;
        logic exec_empty;
        logic exec_run;
        logic scan_step;
        logic load_out;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed
    {
        logic is_add;
        logic empty;
        logic scan_last;
        logic out_busy;
    } dp_stat_t;

endpackage

// ----- rtl/mvts_ctrl.sv -----
// Sequencing controller for the min-vruntime task scheduler.
`timescale 1ns / 1ps

module mvts_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mvts_pkg::dp_stat_t stat,
    output mvts_pkg::dp_cmd_t  cmd
);
    import mvts_pkg::*;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    ready_next  = 1'b0;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                priority if (stat.is_add)
                begin
                    cmd.exec_add = 1'b1;
                    state_next   = S_DONE;
                end
                else if (stat.empty)
                begin
                    cmd.exec_empty = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.exec_run = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last read beat is compared on this edge
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    ready_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready = ready_reg;

endmodule

// ----- rtl/mvts_dp.sv -----
// Datapath: task table memory, running minimum, quantum update and result register.
`timescale 1ns / 1ps

module mvts_dp
#(
    parameter int MAX_TASKS = 64
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  mvts_pkg::dp_cmd_t               cmd,
    output mvts_pkg::dp_stat_t              stat,
    input  logic [mvts_pkg::IN_DATA_W-1:0]  in_data,
    input  logic [0:0]                      in_user,
    input  logic                            cfg_valid,
    input  logic [mvts_pkg::QUANT_W-1:0]    cfg_data,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [mvts_pkg::OUT_DATA_W-1:0] out_data,
    output logic [mvts_pkg::STATUS_W-1:0]   out_user
);
    import mvts_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    function automatic logic key_less
    (
        input logic [RT_W-1:0] rt_a,
        input logic [ID_W-1:0] id_a,
        input logic [RT_W-1:0] rt_b,
        input logic [ID_W-1:0] id_b
    );
        key_less = (rt_a < rt_b) || ((rt_a == rt_b) && (id_a < id_b));
    endfunction

    // latched input beat
    op_t                 op_reg;
    logic [ID_W-1:0]     id_reg;
    logic [RT_W-1:0]     rt_reg;

    logic [QUANT_W-1:0]  quantum_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    // least-key task over the filled slots
    logic                min_valid_reg;
    logic                min_valid_next;
    logic [ID_W-1:0]     min_id_reg;
    logic [ID_W-1:0]     min_id_next;
    logic [RT_W-1:0]     min_rt_reg;
    logic [RT_W-1:0]     min_rt_next;
    logic [IDX_W-1:0]    min_slot_reg;
    logic [IDX_W-1:0]    min_slot_next;

    status_t             status_reg;
    logic [ID_W-1:0]     ran_id_reg;
    logic [RT_W-1:0]     ran_rt_reg;

    // table scan
    logic [IDX_W-1:0]    scan_addr_reg;
    logic [IDX_W-1:0]    scan_addr_next;
    logic [IDX_W-1:0]    rd_slot_reg;
    logic                rd_valid_reg;
    logic [ENTRY_W-1:0]  rd_data_reg;

    logic [ENTRY_W-1:0]  mem [MAX_TASKS];
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;

    logic                out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [STATUS_W-1:0] out_user_reg;

    logic                full;
    logic [RT_W:0]       rt_sum;
    logic [RT_W-1:0]     rt_sat;
    logic [ID_W-1:0]     rd_id;
    logic [RT_W-1:0]     rd_rt;
    logic                take_add;
    logic                take_scan;

    assign full  = (count_reg == CNT_W'(MAX_TASKS));
    assign rd_id = rd_data_reg[ENTRY_W-1:RT_W];
    assign rd_rt = rd_data_reg[RT_W-1:0];

    // saturating runtime update of the chosen task
    assign rt_sum = {1'b0, min_rt_reg} + {{(RT_W + 1 - QUANT_W){1'b0}}, quantum_reg};
    assign rt_sat = rt_sum[RT_W] ? {RT_W{1'b1}} : rt_sum[RT_W-1:0];

    assign mem_we    = (cmd.exec_add && !full) || cmd.exec_run;
    assign mem_waddr = cmd.exec_add ? count_reg[IDX_W-1:0] : min_slot_reg;
    assign mem_wdata = cmd.exec_add ? {id_reg, rt_reg} : {min_id_reg, rt_sat};

    assign take_add  = cmd.exec_add && !full &&
                       (!min_valid_reg || key_less(rt_reg, id_reg, min_rt_reg, min_id_reg));
    assign take_scan = rd_valid_reg &&
                       (!min_valid_reg || key_less(rd_rt, rd_id, min_rt_reg, min_id_reg));

    always_comb
    begin
        count_next     = count_reg;
        min_valid_next = min_valid_reg;
        min_id_next    = min_id_reg;
        min_rt_next    = min_rt_reg;
        min_slot_next  = min_slot_reg;
        scan_addr_next = scan_addr_reg;
        if (cmd.exec_add && !full)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (take_add)
        begin
            min_valid_next = 1'b1;
            min_id_next    = id_reg;
            min_rt_next    = rt_reg;
            min_slot_next  = count_reg[IDX_W-1:0];
        end
        if (cmd.exec_run)
        begin
            // restart the minimum search from scratch
            min_valid_next = 1'b0;
            scan_addr_next = '0;
        end
        if (cmd.scan_step)
        begin
            scan_addr_next = scan_addr_reg + IDX_W'(1);
        end
        if (take_scan)
        begin
            min_valid_next = 1'b1;
            min_id_next    = rd_id;
            min_rt_next    = rd_rt;
            min_slot_next  = rd_slot_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[scan_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg   <= QUANT_RESET;
            count_reg     <= '0;
            min_valid_reg <= 1'b0;
            scan_addr_reg <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                quantum_reg <= cfg_data;
            end
            count_reg     <= count_next;
            min_valid_reg <= min_valid_next;
            scan_addr_reg <= scan_addr_next;
            rd_valid_reg  <= cmd.scan_step;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        min_id_reg   <= min_id_next;
        min_rt_reg   <= min_rt_next;
        min_slot_reg <= min_slot_next;
        if (cmd.scan_step)
        begin
            rd_slot_reg <= scan_addr_reg;
        end
        if (cmd.load_in)
        begin
            op_reg <= op_t'(in_user[0]);
            id_reg <= in_data[ID_W-1:0];
            rt_reg <= in_data[IN_DATA_W-1:ID_W];
        end
        if (cmd.exec_add)
        begin
            status_reg <= full ? ST_FULL : ST_OK;
            ran_id_reg <= '0;
            ran_rt_reg <= '0;
        end
        if (cmd.exec_empty)
        begin
            status_reg <= ST_EMPTY;
            ran_id_reg <= '0;
            ran_rt_reg <= '0;
        end
        if (cmd.exec_run)
        begin
            status_reg <= ST_OK;
            ran_id_reg <= min_id_reg;
            ran_rt_reg <= min_rt_reg;
        end
        if (cmd.load_out)
        begin
            out_user_reg <= status_reg;
            out_data_reg <= {HELD_W'(count_reg),
                             min_valid_reg ? min_rt_reg : {RT_W{1'b0}},
                             min_valid_reg ? min_id_reg : {ID_W{1'b0}},
                             min_valid_reg,
                             ran_rt_reg,
                             ran_id_reg};
        end
    end

    assign stat.is_add    = (op_reg == OP_ADD);
    assign stat.empty     = (count_reg == '0);
    assign stat.scan_last = (CNT_W'(scan_addr_reg) == (count_reg - CNT_W'(1)));
    assign stat.out_busy  = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;

endmodule

// ----- rtl/min_vruntime_task_scheduler.sv -----
// Top level of the min-vruntime task scheduler: controller plus datapath.
// One item at a time; a run is followed by a one-entry-per-cycle rescan of the task
//   table through its single read port.
// An input beat is taken while the previous result still waits in the output register.
// Reset (rst_n, async, active low): table empty, no minimum held, quantum back to 4.
// Table memory contents are not cleared; only filled slots are ever read.
`timescale 1ns / 1ps

module min_vruntime_task_scheduler
#(
    parameter int MAX_TASKS = 64
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // input beat
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: task_id[15:0], start_runtime[63:16]
    input  logic [mvts_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: command[0]
    input  logic [0:0]                      s_axis_tuser,
    // result beat
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: ran_id[15:0], ran_runtime[63:16], next_valid[64], next_id[80:65],
    //        next_runtime[128:81], held_count[135:129]
    output logic [mvts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: status[1:0]
    output logic [mvts_pkg::STATUS_W-1:0]   m_axis_tuser,
    // run_quantum write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mvts_pkg::QUANT_W-1:0]    cfg_data
);
    import mvts_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The quantum register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    // Controller: accept, dispatch add / empty run / run, sequence the table
    // rescan after a run, and hand the finished beat to the output register.
    mvts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: tasks are never removed, so filled slots are always 0..count-1
    // and a fill count replaces per-entry used bits. The least-key task is kept
    // in registers: an add folds the new key in, a run bumps the chosen entry
    // and then rescans every filled slot (the lower id wins on equal runtimes, then the lowest slot).
    mvts_dp
    #(
        .MAX_TASKS (MAX_TASKS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule

// ----- rtl/mvts_checker.sv -----
// Port-level assertions for the min-vruntime task scheduler, bound to the top level.
`timescale 1ns / 1ps

module mvts_checker
#(
    parameter int MAX_TASKS = 64
)
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [mvts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [mvts_pkg::STATUS_W-1:0]   m_axis_tuser
);
    import mvts_pkg::*;

    // a waiting result beat holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result beat changed while stalled");

    // one item in flight: input closes right after a beat is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second input beat taken while busy");

    // a dropped add means the table holds MAX_TASKS
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_FULL)) |->
        (m_axis_tdata[135:129] == HELD_W'(MAX_TASKS)))
        else $error("full status with wrong held count");

    // an ignored run reports an empty table and no chosen task
    a_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_EMPTY)) |->
        (!m_axis_tdata[64] && (m_axis_tdata[135:129] == '0) && (m_axis_tdata[63:0] == '0)))
        else $error("empty status with tasks or a chosen task");

    // minimum is reported exactly when tasks are held (checked while MAX_TASKS < 128)
    a_next_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (MAX_TASKS < 128)) |->
        (m_axis_tdata[64] == (m_axis_tdata[135:129] != '0)))
        else $error("next_valid disagrees with held count");

endmodule

bind min_vruntime_task_scheduler mvts_checker #(.MAX_TASKS(MAX_TASKS)) u_mvts_checker (.*);
